FILE: rtl/rfr_pkg.sv
// Package of the 3x3 rank-order filter: shared types, codes and defaults.
// Used by every module of the filter but rfr_ram; depends on nothing.
`default_nettype none

package rfr_pkg;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CHANNELS_DEF  = 3;

    // Configuration register indexes and reset values
    localparam logic [1:0]  REG_RANK   = 2'd0;
    localparam logic [1:0]  REG_WIDTH  = 2'd1;
    localparam logic [1:0]  REG_HEIGHT = 2'd2;
    localparam logic [3:0]  RANK_RESET   = 4'd4;
    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd480;

    // Input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Highest meaningful rank in a nine-value window
    localparam logic [3:0] RANK_MAX = 4'd8;
    localparam int         TAPS     = 9;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One classified transaction handed from front to back
    typedef struct packed {
        logic [7:0] upper;   // sample two rows up
        logic [7:0] lower;   // sample one row up
        logic [7:0] smp;     // current sample
        logic       emit;    // this transaction produces a result
        logic       up;      // neighbour row above is inside the image
        logic       down;    // neighbour row below is inside the image
        logic       left;    // left neighbour is inside the image
        logic       right;   // right neighbour is inside the image
        logic       last;    // final result of the image
        logic [1:0] chan;    // channel of the result
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/rfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3072
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents before a write in the same cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/rfr_front.sv
// Front of the rank filter: accepts transactions, keeps the raster counters,
// reads and updates the two line buffers and classifies each transaction.
// Depends on rfr_pkg and rfr_ram.
`default_nettype none

module rfr_front #(
    parameter int MAX_WIDTH = rfr_pkg::MAX_WIDTH_DEF,
    parameter int CHANNELS  = rfr_pkg::CHANNELS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [10:0]   width_cfg,
    input  wire logic [10:0]   height_cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_cmd,
    input  wire logic [7:0]    in_sample,
    input  wire logic [$clog2(rfr_pkg::QUEUE_DEPTH+1)-1:0] queue_count,
    output logic               push,
    output rfr_pkg::item_t     push_item
);

    localparam int COLS  = MAX_WIDTH * CHANNELS;
    localparam int COL_W = $clog2(COLS + 1);
    localparam int AW    = $clog2(COLS);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int O_W   = COL_W + 11;
    localparam int BW    = $clog2(O_W + 3);
    localparam int QW    = $clog2(rfr_pkg::QUEUE_DEPTH + 1);

    // Effective geometry, registered
    logic [EW-1:0]    weff;
    logic [10:0]      heff;
    logic [COL_W-1:0] wc_reg;
    logic [O_W-1:0]   total_reg;

    always_comb begin
        if (width_cfg == 11'd0) begin
            weff = EW'(1);
        end else if (32'(width_cfg) > 32'(MAX_WIDTH)) begin
            weff = EW'(MAX_WIDTH);
        end else begin
            weff = EW'(width_cfg);
        end
        heff = (height_cfg == 11'd0) ? 11'd1 : height_cfg;
    end

    always_ff @(posedge aclk) begin
        wc_reg    <= COL_W'(32'(weff) * CHANNELS);
        total_reg <= O_W'(wc_reg) * O_W'(heff);
    end

    // Counters
    logic [COL_W-1:0] in_col_reg;
    logic [10:0]      in_row_reg;
    logic [O_W-1:0]   o_reg;
    logic [O_W-1:0]   orow_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [1:0]       chan_reg;
    logic [BW-1:0]    busy_reg;
    logic [COL_W:0]   rem_reg;
    logic [O_W-1:0]   quot_reg;

    logic             accept;
    logic [COL_W-1:0] col_a, col_b;
    logic [10:0]      row_a, row_b;
    logic             emit, f_up, f_down, f_left, f_right, f_last;
    logic [7:0]       smp;

    // Input position, row advance and result classification
    always_comb begin
        col_a = in_col_reg;
        row_a = in_row_reg;
        if (col_a >= wc_reg) begin
            col_a = '0;
            row_a = (row_a == 11'd2047) ? row_a : row_a + 11'd1;
        end
        emit = (row_a >= 11'd2) ||
               (row_a == 11'd1 && col_a >= COL_W'(CHANNELS));
        col_b = col_a + COL_W'(1);
        row_b = row_a;
        if (col_b >= wc_reg) begin
            col_b = '0;
            row_b = (row_a == 11'd2047) ? row_a : row_a + 11'd1;
        end
        f_up    = (orow_reg != '0);
        f_down  = ({1'b0, orow_reg} + (O_W+1)'(1)) < (O_W+1)'(heff);
        f_left  = ocol_reg >= COL_W'(CHANNELS);
        f_right = ({1'b0, ocol_reg} + (COL_W+1)'(CHANNELS)) < {1'b0, wc_reg};
        f_last  = ({1'b0, o_reg} + (O_W+1)'(1)) >= {1'b0, total_reg};
        smp     = (in_cmd == rfr_pkg::CMD_FLUSH) ? 8'd0 : in_sample;
    end

    // Room is reserved for the transaction still waiting on the line buffer.
    assign in_ready = (busy_reg == '0) &&
                      ((QW+1)'(queue_count) + (QW+1)'(push)) <
                      (QW+1)'(rfr_pkg::QUEUE_DEPTH);
    assign accept = in_valid && in_ready;

    // Division step for re-deriving output row and column after a write
    logic [COL_W:0] div_tmp;
    logic           div_ge;
    always_comb begin
        div_tmp = {rem_reg[COL_W-1:0], quot_reg[O_W-1]};
        div_ge  = div_tmp >= {1'b0, wc_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            o_reg      <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            chan_reg   <= '0;
            busy_reg   <= BW'(O_W + 2);
        end else if (cfg_wr_en) begin
            busy_reg <= BW'(O_W + 2);
        end else if (busy_reg != '0) begin
            // Restoring division of the output count by the row length
            busy_reg <= busy_reg - BW'(1);
            if (busy_reg == BW'(O_W + 1)) begin
                quot_reg <= o_reg;
                rem_reg  <= '0;
            end else if (busy_reg <= BW'(O_W)) begin
                quot_reg <= {quot_reg[O_W-2:0], div_ge};
                rem_reg  <= div_ge ? div_tmp - {1'b0, wc_reg} : div_tmp;
                orow_reg <= {quot_reg[O_W-2:0], div_ge};
                ocol_reg <= COL_W'(div_ge ? div_tmp - {1'b0, wc_reg} : div_tmp);
            end
        end else if (accept) begin
            if (emit && f_last) begin
                // Final result of the image: every counter starts again.
                in_col_reg <= '0;
                in_row_reg <= '0;
                o_reg      <= '0;
                orow_reg   <= '0;
                ocol_reg   <= '0;
                chan_reg   <= '0;
            end else begin
                in_col_reg <= col_b;
                in_row_reg <= row_b;
                if (emit) begin
                    o_reg    <= o_reg + O_W'(1);
                    chan_reg <= (chan_reg == 2'(CHANNELS - 1)) ? 2'd0 : chan_reg + 2'd1;
                    if (ocol_reg + COL_W'(1) >= wc_reg) begin
                        ocol_reg <= '0;
                        orow_reg <= orow_reg + O_W'(1);
                    end else begin
                        ocol_reg <= ocol_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // Second stage: line-buffer data returns, buffers are updated
    logic             f2_valid_reg;
    logic [AW-1:0]    f2_addr_reg;
    rfr_pkg::item_t   f2_item_reg;
    logic             fwd_hit_reg;
    logic [15:0]      fwd_data_reg;
    logic [15:0]      ram_q;
    logic [15:0]      rows_now;
    logic [15:0]      wr_data;

    assign rows_now = fwd_hit_reg ? fwd_data_reg : ram_q;
    assign wr_data  = {rows_now[7:0], f2_item_reg.smp};

    rfr_ram #(
        .WIDTH (16),
        .DEPTH (COLS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (f2_valid_reg),
        .wr_addr (f2_addr_reg),
        .wr_data (wr_data),
        .rd_addr (col_a[AW-1:0]),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else begin
            f2_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f2_addr_reg        <= col_a[AW-1:0];
            fwd_hit_reg        <= f2_valid_reg && (f2_addr_reg == col_a[AW-1:0]);
            fwd_data_reg       <= wr_data;
            f2_item_reg.upper  <= 8'd0;
            f2_item_reg.lower  <= 8'd0;
            f2_item_reg.smp    <= smp;
            f2_item_reg.emit   <= emit;
            f2_item_reg.up     <= f_up;
            f2_item_reg.down   <= f_down;
            f2_item_reg.left   <= f_left;
            f2_item_reg.right  <= f_right;
            f2_item_reg.last   <= f_last;
            f2_item_reg.chan   <= chan_reg;
        end
    end

    // Hand the completed transaction to the queue
    always_comb begin
        push            = f2_valid_reg;
        push_item       = f2_item_reg;
        push_item.upper = rows_now[15:8];
        push_item.lower = rows_now[7:0];
    end

endmodule

`default_nettype wire

FILE: rtl/rfr_queue.sv
// Short queue between the front and the back of the rank filter.
// Depends on rfr_pkg.
`default_nettype none

module rfr_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  rfr_pkg::item_t            push_item,
    input  wire logic                 pop,
    output rfr_pkg::item_t            head,
    output logic                      empty,
    output logic [$clog2(rfr_pkg::QUEUE_DEPTH+1)-1:0] count
);

    localparam int DEPTH = rfr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rfr_pkg::item_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_pop;

    assign empty  = (count_reg == '0);
    assign count  = count_reg;
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rfr_back.sv
// Back of the rank filter: window registers, rank selection over the nine
// neighbours and the output register. Depends on rfr_pkg.
`default_nettype none

module rfr_back #(
    parameter int CHANNELS = rfr_pkg::CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [3:0]  rank_cfg,
    input  rfr_pkg::item_t   head,
    input  wire logic        empty,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_value,
    output logic [1:0]       out_chan,
    output logic             out_last
);

    localparam int WIN = 3 * CHANNELS;
    localparam int N   = rfr_pkg::TAPS;

    logic advance;
    assign advance = !out_valid || out_ready;
    assign pop     = advance && !empty;

    // Window columns: index 0 is the newest
    logic [7:0] win_reg [WIN][3];
    logic [7:0] v [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WIN; k++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[k][r] <= 8'd0;
                end
            end
        end else if (pop) begin
            for (int k = WIN - 1; k > 0; k--) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[k][r] <= win_reg[k-1][r];
                end
            end
            win_reg[0][0] <= head.upper;
            win_reg[0][1] <= head.lower;
            win_reg[0][2] <= head.smp;
        end
    end

    // Neighbourhood with positions outside the image forced to zero
    always_comb begin
        v[0] = (head.up && head.left)    ? win_reg[2*CHANNELS-1][0] : 8'd0;
        v[1] =  head.left                ? win_reg[2*CHANNELS-1][1] : 8'd0;
        v[2] = (head.down && head.left)  ? win_reg[2*CHANNELS-1][2] : 8'd0;
        v[3] =  head.up                  ? win_reg[CHANNELS-1][0]   : 8'd0;
        v[4] =  win_reg[CHANNELS-1][1];
        v[5] =  head.down                ? win_reg[CHANNELS-1][2]   : 8'd0;
        v[6] = (head.up && head.right)   ? head.upper               : 8'd0;
        v[7] =  head.right               ? head.lower               : 8'd0;
        v[8] = (head.down && head.right) ? head.smp                 : 8'd0;
    end

    // Stage 1: registered neighbourhood
    logic       s1_valid_reg;
    logic [7:0] s1_v_reg [N];
    logic [1:0] s1_chan_reg;
    logic       s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= pop && head.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_v_reg    <= v;
            s1_chan_reg <= head.chan;
            s1_last_reg <= head.last;
        end
    end

    // Stage 2: sorted position of each value, ties broken by index
    logic [3:0] pos [N];
    always_comb begin
        for (int i = 0; i < N; i++) begin
            pos[i] = 4'd0;
            for (int j = 0; j < N; j++) begin
                if (j != i && (s1_v_reg[j] < s1_v_reg[i] ||
                               (s1_v_reg[j] == s1_v_reg[i] && j < i))) begin
                    pos[i] = pos[i] + 4'd1;
                end
            end
        end
    end

    logic       s2_valid_reg;
    logic [7:0] s2_v_reg [N];
    logic [3:0] s2_pos_reg [N];
    logic [1:0] s2_chan_reg;
    logic       s2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_v_reg    <= s1_v_reg;
            s2_pos_reg  <= pos;
            s2_chan_reg <= s1_chan_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: pick the value whose sorted position equals the rank
    logic [3:0] rank_sat;
    logic [7:0] picked;
    always_comb begin
        rank_sat = (rank_cfg > rfr_pkg::RANK_MAX) ? rfr_pkg::RANK_MAX : rank_cfg;
        picked   = 8'd0;
        for (int i = 0; i < N; i++) begin
            if (s2_pos_reg[i] == rank_sat) begin
                picked = s2_v_reg[i];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (advance) begin
            out_valid <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_value <= picked;
            out_chan  <= s2_chan_reg;
            out_last  <= s2_last_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rank_filter_3x3_rgb.sv
// Top level of the 3x3 rank-order filter for interleaved channel streams.
// Depends on rfr_pkg, rfr_front, rfr_queue, rfr_back and rfr_ram.
//
// One channel sample is taken per clock cycle when the result side keeps up
// and no division is in progress. Each sample passes the front (line-buffer
// read and update), a queue of four entries and the back (window, sorted
// positions, selection) before it reaches the output register. Results
// leave one image row plus one pixel after their sample, so the bottom row
// is pushed out with flush transactions (tuser high). The line buffers are
// not cleared at reset; rows not yet written are masked out by the output
// row position. After reset and after every configuration write the input
// is held off while the output row and column are re-derived by a
// bit-serial divider.
`default_nettype none

module rank_filter_3x3_rgb #(
    parameter int MAX_WIDTH = rfr_pkg::MAX_WIDTH_DEF,
    parameter int CHANNELS  = rfr_pkg::CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [10:0] cfg_wr_data,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] sample
    input  wire logic        s_tuser,     // [0] cmd: 0 sample, 1 flush
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // [7:0] value
    output logic [1:0]       m_tuser,     // [1:0] channel
    output logic             m_tlast      // last_of_frame
);

    // Configuration registers
    logic [3:0]  rank_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg   <= rfr_pkg::RANK_RESET;
            width_reg  <= rfr_pkg::WIDTH_RESET;
            height_reg <= rfr_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rfr_pkg::REG_RANK:   rank_reg   <= cfg_wr_data[3:0];
                rfr_pkg::REG_WIDTH:  width_reg  <= cfg_wr_data;
                rfr_pkg::REG_HEIGHT: height_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    logic                 push, pop, empty;
    rfr_pkg::item_t       push_item, head;
    logic [$clog2(rfr_pkg::QUEUE_DEPTH+1)-1:0] queue_count;

    rfr_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_sample   (s_tdata),
        .queue_count (queue_count),
        .push        (push),
        .push_item   (push_item)
    );

    rfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (queue_count)
    );

    rfr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rank_cfg  (rank_reg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_chan  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire
